### src/mulliken_shell_population_top_macros.svh
// Assertion macros for the Mulliken shell population block.
`ifndef MULLIKEN_SHELL_POPULATION_TOP_MACROS_SVH
`define MULLIKEN_SHELL_POPULATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MSP_ASSERT(lbl, prop, msg)
`define MSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/msp_pkg.sv
// Shared constants for the Mulliken shell population block.
package msp_pkg;

  localparam int unsigned MAX_SHELLS_DEF  = 16;
  localparam int unsigned MAX_ATOMS_DEF   = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 48;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned TERM_W = 41;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned CNT_W  = 5;

  localparam logic [1:0] FN_SET = 2'd0;
  localparam logic [1:0] FN_ACC = 2'd1;
  localparam logic [1:0] FN_FIN = 2'd2;

  localparam logic [1:0] REG_SPIN  = 2'd0;
  localparam logic [1:0] REG_SHELL = 2'd1;
  localparam logic [1:0] REG_ATOM  = 2'd2;

  localparam logic [1:0] SPIN_RST  = 2'd1;
  localparam logic [4:0] SHELL_RST = 5'd16;
  localparam logic [4:0] ATOM_RST  = 5'd16;

endpackage

### src/msp_term.sv
// Registered density times overlap product, negated and rounded to Q16.32.
module msp_term (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [msp_pkg::IN_W-1:0]         density_i,
  input  logic signed [msp_pkg::IN_W-1:0]         overlap_i,
  output logic signed [msp_pkg::TERM_W-1:0]       term_o
);

  logic signed [msp_pkg::PROD_W-1:0] prod_q;
  logic signed [msp_pkg::PROD_W:0]   neg;
  logic signed [msp_pkg::PROD_W:0]   rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= density_i * overlap_i;
    end
  end

  assign neg    = -{prod_q[msp_pkg::PROD_W-1], prod_q};
  assign rnd    = neg + (65'sd1 <<< 23);
  assign term_o = rnd[msp_pkg::PROD_W:24];

endmodule

### src/mulliken_shell_population_top.sv
// Top level of the Mulliken shell and atom population block.
// Items are taken when start_i is high and busy_o low. A set-shell item completes
// on acceptance; an element item registers the multiply, then does a read-modify-write
// of the shell accumulator memory in S_EADD. A finish item forms shell values and atom
// sums (read, compute, atom memory update per shell: S_FRD, S_FCALC, S_FATOM), then
// reads each result through the memory read port (S_ORD, S_OOUT), (ns+na)*spins results in all;
// results appear with result_valid_o for one cycle each and cannot be held off.
// Accumulators clear through valid bits, so there is no clearing pass after reset.
module mulliken_shell_population_top #(
  parameter int unsigned MAX_SHELLS  = msp_pkg::MAX_SHELLS_DEF,
  parameter int unsigned MAX_ATOMS   = msp_pkg::MAX_ATOMS_DEF,
  parameter int unsigned VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [4:0]                        cfg_data_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic                              spin_i,
  input  logic [3:0]                        shell_index_i,
  input  logic [3:0]                        atom_index_i,
  input  logic signed [31:0]                density_value_i,
  input  logic signed [31:0]                overlap_value_i,
  input  logic signed [47:0]                reference_value_i,
  output logic                              result_valid_o,
  output logic                              kind_o,
  output logic                              channel_o,
  output logic [3:0]                        index_o,
  output logic signed [47:0]                value_o,
  output logic                              error_flag_o,
  output logic                              last_o
);

  `include "mulliken_shell_population_top_macros.svh"

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned TW  = msp_pkg::TERM_W;
  localparam int unsigned OW  = msp_pkg::OUT_W;
  localparam int unsigned SW  = ((VW > OW) ? VW : OW) + 2;
  localparam int unsigned SAW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
  localparam int unsigned AAW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned CW  = msp_pkg::CNT_W;
  localparam logic signed [SW-1:0] VMAX = (SW'(1) <<< (VW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_EADD, S_FRD, S_FCALC, S_FATOM, S_ORD, S_OOUT
  } state_e;

  function automatic logic signed [SW-1:0] ext_f(input logic signed [VW-1:0] v);
    ext_f = {{(SW-VW){v[VW-1]}}, v};
  endfunction

  function automatic logic signed [VW-1:0] sat_f(input logic signed [SW-1:0] x);
    if (x > VMAX) sat_f = VMAX[VW-1:0];
    else if (x < VMIN) sat_f = VMIN[VW-1:0];
    else sat_f = x[VW-1:0];
  endfunction

  function automatic logic ovf_f(input logic signed [SW-1:0] x);
    ovf_f = (x > VMAX) || (x < VMIN);
  endfunction

  function automatic logic [CW-1:0] clamp_f(input logic [CW-1:0] v,
                                            input logic [CW-1:0] hi);
    if (v == '0) clamp_f = CW'(1);
    else if (v > hi) clamp_f = hi;
    else clamp_f = v;
  endfunction

  state_e state_q;
  logic [1:0]     spin_cnt_q;
  logic [CW-1:0]  shell_cnt_q, atom_cnt_q;
  logic           sticky_q;
  logic [CW-1:0]  cnt_q;
  logic           ch_q, kind_q, spin_q;
  logic [SAW-1:0] shell_q;
  logic signed [VW-1:0] val0_q, val1_q;
  logic [3:0]     amap_q;
  logic [MAX_SHELLS-1:0] sh_vld_q, rf_vld_q;
  logic [MAX_ATOMS-1:0]  at_vld_q;

  logic           res_vld_q, res_kind_q, res_ch_q, res_err_q, res_last_q;
  logic [3:0]     res_idx_q;
  logic [OW-1:0]  res_val_q;

  logic [2*VW-1:0] sh_mem [MAX_SHELLS];
  logic [VW+3:0]   rf_mem [MAX_SHELLS];
  logic [2*VW-1:0] at_mem [MAX_ATOMS];
  logic [2*VW-1:0] sh_rd_q, at_rd_q;
  logic [VW+3:0]   rf_rd_q;
  logic            sh_rv_q, rf_rv_q, at_rv_q;

  logic [SAW-1:0]  sh_ra, sh_wa;
  logic [AAW-1:0]  at_ra;
  logic            sh_we, at_we, rf_we;
  logic [2*VW-1:0] sh_wd, at_wd;
  logic [VW+3:0]   rf_wd;

  logic accept, nsp2, err_set;
  logic [CW-1:0] ns, na;
  logic signed [TW-1:0] term;

  logic signed [VW-1:0] old0, old1, osel, enew;
  logic signed [SW-1:0] esum;
  logic signed [VW-1:0] al, be, rf, t1, v0, v1, a0, a1, n0, n1, ocv;
  logic [3:0]           map;
  logic signed [SW-1:0] sab, sc, sd, s1, sa0, sa1, rx;
  logic signed [VW-1:0] rsat;
  logic signed [SW-1:0] oext;
  logic                 endrow, endch, lastres;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign nsp2   = spin_cnt_q[1];
  assign ns     = clamp_f(shell_cnt_q, CW'(MAX_SHELLS));
  assign na     = clamp_f(atom_cnt_q, CW'(MAX_ATOMS));

  msp_term u_term (
    .clk_i     (clk_i),
    .en_i      (accept),
    .density_i (density_value_i),
    .overlap_i (overlap_value_i),
    .term_o    (term)
  );

  // element update
  assign old0 = sh_rv_q ? sh_rd_q[VW-1:0] : '0;
  assign old1 = sh_rv_q ? sh_rd_q[2*VW-1:VW] : '0;
  assign osel = spin_q ? old1 : old0;
  assign esum = ext_f(osel) + {{(SW-TW){term[TW-1]}}, term};
  assign enew = sat_f(esum);

  // shell values
  assign al  = old0;
  assign be  = old1;
  assign rf  = rf_rv_q ? rf_rd_q[VW-1:0] : '0;
  assign map = rf_rv_q ? rf_rd_q[VW+3:VW] : 4'd0;
  assign sab = ext_f(al) + ext_f(be);
  assign t1  = sat_f(sab);
  assign sc  = nsp2 ? ext_f(t1) + ext_f(rf) : ext_f(al) + ext_f(rf);
  assign v0  = sat_f(sc);
  assign sd  = ext_f(al) - ext_f(be);
  assign v1  = nsp2 ? sat_f(sd) : '0;
  assign s1  = sd;

  // atom sums
  assign a0  = at_rv_q ? at_rd_q[VW-1:0] : '0;
  assign a1  = at_rv_q ? at_rd_q[2*VW-1:VW] : '0;
  assign sa0 = ext_f(a0) + ext_f(val0_q);
  assign sa1 = ext_f(a1) + ext_f(val1_q);
  assign n0  = sat_f(sa0);
  assign n1  = nsp2 ? sat_f(sa1) : a1;

  assign rx   = {{(SW-OW){reference_value_i[OW-1]}}, reference_value_i};
  assign rsat = sat_f(rx);

  // result readout
  assign ocv     = kind_q ? (ch_q ? a1 : a0)
                          : (ch_q ? sh_rd_q[2*VW-1:VW] : sh_rd_q[VW-1:0]);
  assign oext    = ext_f(ocv);
  assign endrow  = (cnt_q + CW'(1)) == (kind_q ? na : ns);
  assign endch   = endrow && (ch_q || !nsp2);
  assign lastres = endch && kind_q;

  always_comb begin
    sh_ra = cnt_q[SAW-1:0];
    if (state_q == S_IDLE) sh_ra = shell_index_i[SAW-1:0];
    else if (state_q == S_EADD) sh_ra = shell_q;
    at_ra = (state_q == S_FCALC) ? map[AAW-1:0] : cnt_q[AAW-1:0];
    sh_we = 1'b0;
    sh_wa = shell_q;
    sh_wd = '0;
    at_we = 1'b0;
    at_wd = {n1, n0};
    rf_we = accept && (func_i == msp_pkg::FN_SET) && (32'(shell_index_i) < MAX_SHELLS);
    rf_wd = {atom_index_i, rsat};
    err_set = rf_we && ovf_f(rx);
    unique case (state_q)
      S_EADD: begin
        sh_we   = 1'b1;
        sh_wd   = spin_q ? {enew, old0} : {old1, enew};
        err_set = ovf_f(esum);
      end
      S_FCALC: begin
        sh_we   = 1'b1;
        sh_wa   = cnt_q[SAW-1:0];
        sh_wd   = {v1, v0};
        err_set = nsp2 ? (ovf_f(sab) || ovf_f(sc) || ovf_f(s1)) : ovf_f(sc);
      end
      S_FATOM: begin
        at_we   = {1'b0, amap_q} < na;
        err_set = at_we && (ovf_f(sa0) || (nsp2 && ovf_f(sa1)));
      end
      S_IDLE, S_FRD, S_ORD, S_OOUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sh_rd_q <= sh_mem[sh_ra];
    sh_rv_q <= sh_vld_q[sh_ra];
    rf_rd_q <= rf_mem[cnt_q[SAW-1:0]];
    rf_rv_q <= rf_vld_q[cnt_q[SAW-1:0]];
    at_rd_q <= at_mem[at_ra];
    at_rv_q <= at_vld_q[at_ra];
    if (sh_we) sh_mem[sh_wa] <= sh_wd;
    if (rf_we) rf_mem[shell_index_i[SAW-1:0]] <= rf_wd;
    if (at_we) at_mem[amap_q[AAW-1:0]] <= at_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spin_cnt_q  <= msp_pkg::SPIN_RST;
      shell_cnt_q <= msp_pkg::SHELL_RST;
      atom_cnt_q  <= msp_pkg::ATOM_RST;
      sticky_q    <= 1'b0;
      cnt_q       <= '0;
      ch_q        <= 1'b0;
      kind_q      <= 1'b0;
      spin_q      <= 1'b0;
      shell_q     <= '0;
      amap_q      <= '0;
      sh_vld_q    <= '0;
      rf_vld_q    <= '0;
      at_vld_q    <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      if (err_set) sticky_q <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          msp_pkg::REG_SPIN:  spin_cnt_q  <= cfg_data_i[1:0];
          msp_pkg::REG_SHELL: shell_cnt_q <= cfg_data_i;
          msp_pkg::REG_ATOM:  atom_cnt_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (rf_we) rf_vld_q[shell_index_i[SAW-1:0]] <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            spin_q  <= spin_i;
            shell_q <= shell_index_i[SAW-1:0];
            cnt_q   <= '0;
            if (func_i == msp_pkg::FN_ACC && 32'(shell_index_i) < MAX_SHELLS &&
                (!spin_i || nsp2)) begin
              state_q <= S_EADD;
            end else if (func_i == msp_pkg::FN_FIN) begin
              at_vld_q <= '0;
              state_q  <= S_FRD;
            end
          end
        end
        S_EADD: begin
          sh_vld_q[shell_q] <= 1'b1;
          state_q <= S_IDLE;
        end
        S_FRD: state_q <= S_FCALC;
        S_FCALC: begin
          val0_q  <= v0;
          val1_q  <= v1;
          amap_q  <= map;
          state_q <= S_FATOM;
        end
        S_FATOM: begin
          if (at_we) at_vld_q[amap_q[AAW-1:0]] <= 1'b1;
          if ((cnt_q + CW'(1)) == ns) begin
            cnt_q   <= '0;
            ch_q    <= 1'b0;
            kind_q  <= 1'b0;
            state_q <= S_ORD;
          end else begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_FRD;
          end
        end
        S_ORD: state_q <= S_OOUT;
        S_OOUT: begin
          res_vld_q  <= 1'b1;
          res_kind_q <= kind_q;
          res_ch_q   <= ch_q;
          res_idx_q  <= cnt_q[3:0];
          res_val_q  <= oext[OW-1:0];
          res_err_q  <= sticky_q;
          res_last_q <= lastres;
          if (lastres) begin
            sticky_q <= 1'b0;
            sh_vld_q <= '0;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_ORD;
            if (endch) begin
              kind_q <= 1'b1;
              ch_q   <= 1'b0;
              cnt_q  <= '0;
            end else if (endrow) begin
              ch_q  <= 1'b1;
              cnt_q <= '0;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_vld_q;
  assign kind_o         = res_kind_q;
  assign channel_o      = res_ch_q;
  assign index_o        = res_idx_q;
  assign value_o        = res_val_q;
  assign error_flag_o   = res_err_q;
  assign last_o         = res_last_q;

  `MSP_ASSERT(a_mid_run_busy, result_valid_o && !last_o |-> busy_o, "result outside finish run")
  `MSP_ASSERT(a_fin_busy, accept && func_i == msp_pkg::FN_FIN |=> busy_o, "finish not started")
  `MSP_ASSERT(a_last_gap, result_valid_o && last_o |=> !result_valid_o, "result after last")
  `MSP_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !busy_o, "busy after reset")

endmodule

### test/tb_top.sv
// Testbench for mulliken_shell_population_top: directed and random items checked against a predictor.
module tb_top;

  typedef struct packed {
    logic        kind;
    logic        channel;
    logic [3:0]  index;
    logic [47:0] value;
    logic        err;
    logic        last;
  } pop_result_t;

  localparam longint VMAX = (64'sd1 <<< 47) - 1;
  localparam longint VMIN = -(64'sd1 <<< 47);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = msp_pkg::REG_SPIN;
  logic [4:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] func_i = msp_pkg::FN_SET;
  logic spin_i = 1'b0;
  logic [3:0] shell_index_i = '0;
  logic [3:0] atom_index_i = '0;
  logic signed [31:0] density_value_i = '0;
  logic signed [31:0] overlap_value_i = '0;
  logic signed [47:0] reference_value_i = '0;
  logic result_valid_o, kind_o, channel_o, error_flag_o, last_o;
  logic [3:0] index_o;
  logic signed [47:0] value_o;

  mulliken_shell_population_top dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // predictor state
  logic [1:0] spin_cfg = 2'd1;
  logic [4:0] shell_cfg = 5'd16, atom_cfg = 5'd16;
  longint shell_acc [32];
  longint ref_occ [16];
  logic [3:0] atom_of [16];
  bit sat_err;
  pop_result_t pending_q[$];
  int failures = 0, results_seen = 0, items_sent = 0;
  bit quiet = 0;

  function automatic longint clamp48(longint x);
    if (x > VMAX) begin sat_err = 1; return VMAX; end
    if (x < VMIN) begin sat_err = 1; return VMIN; end
    return x;
  endfunction

  function automatic void predict_item(logic [1:0] fn, logic sp, logic [3:0] sh, logic [3:0] at,
                                       longint d, longint o, longint rv);
    int nspin, ns, na, first;
    longint term;
    longint vals [2][16];
    longint sums [2][16];
    pop_result_t r;
    nspin = (spin_cfg >= 2) ? 2 : 1;
    ns = (shell_cfg < 1) ? 1 : (shell_cfg > 16) ? 16 : shell_cfg;
    na = (atom_cfg < 1) ? 1 : (atom_cfg > 16) ? 16 : atom_cfg;
    if (fn == msp_pkg::FN_SET) begin
      ref_occ[sh] = rv;
      atom_of[sh] = at;
    end else if (fn == msp_pkg::FN_ACC) begin
      if (sp < nspin) begin
        term = (-(d * o) + (64'sd1 <<< 23)) >>> 24;
        shell_acc[sp*16+sh] = clamp48(shell_acc[sp*16+sh] + term);
      end
    end else if (fn == msp_pkg::FN_FIN) begin
      for (int s = 0; s < ns; s++) begin
        if (nspin == 1) vals[0][s] = clamp48(shell_acc[s] + ref_occ[s]);
        else begin
          vals[0][s] = clamp48(clamp48(shell_acc[s] + shell_acc[16+s]) + ref_occ[s]);
          vals[1][s] = clamp48(shell_acc[s] - shell_acc[16+s]);
        end
      end
      for (int c = 0; c < 2; c++) for (int a = 0; a < 16; a++) sums[c][a] = 0;
      for (int c = 0; c < nspin; c++)
        for (int s = 0; s < ns; s++)
          if (atom_of[s] < na) sums[c][atom_of[s]] = clamp48(sums[c][atom_of[s]] + vals[c][s]);
      first = pending_q.size();
      for (int c = 0; c < nspin; c++)
        for (int s = 0; s < ns; s++) begin
          r = '{1'b0, c[0], s[3:0], vals[c][s][47:0], 1'b0, 1'b0};
          pending_q.push_back(r);
        end
      for (int c = 0; c < nspin; c++)
        for (int a = 0; a < na; a++) begin
          r = '{1'b1, c[0], a[3:0], sums[c][a][47:0], 1'b0, 1'b0};
          pending_q.push_back(r);
        end
      for (int i = first; i < pending_q.size(); i++) pending_q[i].err = sat_err;
      pending_q[pending_q.size()-1].last = 1'b1;
      for (int i = 0; i < 32; i++) shell_acc[i] = 0;
      sat_err = 0;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pop_result_t got, want;
    if (rst_ni && result_valid_o) begin
      got = '{kind_o, channel_o, index_o, value_o, error_flag_o, last_o};
      results_seen++;
      if (pending_q.size() == 0) begin
        failures++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          failures++;
          $display("%0t: mismatch expected kind %0d ch %0d idx %0d val %h err %0d last %0d",
                   $time, want.kind, want.channel, want.index, want.value, want.err, want.last);
          $display("%0t:          actual kind %0d ch %0d idx %0d val %h err %0d last %0d",
                   $time, got.kind, got.channel, got.index, got.value, got.err, got.last);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] fn, logic sp, logic [3:0] sh, logic [3:0] at,
                           logic [31:0] d, logic [31:0] o, logic [47:0] rv);
    start_i <= 1'b1;
    func_i <= fn;
    spin_i <= sp;
    shell_index_i <= sh;
    atom_index_i <= at;
    density_value_i <= d;
    overlap_value_i <= o;
    reference_value_i <= rv;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
    predict_item(fn, sp, sh, at, longint'($signed(d)), longint'($signed(o)),
                 longint'($signed(rv)));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == msp_pkg::REG_SPIN) spin_cfg = data[1:0];
    else if (idx == msp_pkg::REG_SHELL) shell_cfg = data;
    else if (idx == msp_pkg::REG_ATOM) atom_cfg = data;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 5))
      0: return 48'h8000_0000_0000;
      1: return 48'h7fff_ffff_ffff;
      default: return 48'({$urandom_range(0, 65535), $urandom} >>> $urandom_range(0, 20));
    endcase
  endfunction

  task automatic test_directed();
    send_item(msp_pkg::FN_SET, 1'b0, 4'd0, 4'd0, '0, '0, 48'h7fff_ffff_ffff);
    send_item(msp_pkg::FN_SET, 1'b1, 4'd15, 4'd15, '0, '0, 48'h8000_0000_0000);
    send_item(msp_pkg::FN_SET, 1'b0, 4'd1, 4'd0, '0, '0, 48'h7fff_ffff_ffff);
    send_item(msp_pkg::FN_ACC, 1'b0, 4'd0, 4'd0, 32'h8000_0000, 32'h8000_0000, '0);
    send_item(msp_pkg::FN_ACC, 1'b0, 4'd0, 4'd0, 32'h7fff_ffff, 32'h8000_0000, '0);
    send_item(msp_pkg::FN_ACC, 1'b0, 4'd15, 4'd0, 32'hffff_ffff, 32'h0000_0001, '0);
    send_item(msp_pkg::FN_ACC, 1'b1, 4'd3, 4'd0, 32'h1000_0000, 32'h1000_0000, '0);
    send_item(2'd3, 1'b1, 4'd15, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 48'hffff_ffff_ffff);
    send_item(msp_pkg::FN_FIN, 1'b0, 4'd0, 4'd0, '0, '0, '0);
    send_item(msp_pkg::FN_FIN, 1'b0, 4'd0, 4'd0, '0, '0, '0);
  endtask

  task automatic test_config_extremes();
    write_reg(msp_pkg::REG_SPIN, 5'd2);
    write_reg(msp_pkg::REG_SHELL, 5'd3);
    write_reg(msp_pkg::REG_ATOM, 5'd2);
    send_item(msp_pkg::FN_SET, 1'b0, 4'd2, 4'd1, '0, '0, 48'h0000_0001_0000);
    send_item(msp_pkg::FN_ACC, 1'b0, 4'd1, 4'd0, 32'h8000_0000, 32'h7fff_ffff, '0);
    send_item(msp_pkg::FN_ACC, 1'b1, 4'd1, 4'd0, 32'h7fff_ffff, 32'h8000_0000, '0);
    send_item(msp_pkg::FN_FIN, 1'b0, 4'd0, 4'd0, '0, '0, '0);
    write_reg(msp_pkg::REG_SPIN, 5'd0);
    write_reg(msp_pkg::REG_SHELL, 5'd0);
    write_reg(msp_pkg::REG_ATOM, 5'd31);
    send_item(msp_pkg::FN_FIN, 1'b0, 4'd0, 4'd0, '0, '0, '0);
    write_reg(msp_pkg::REG_SPIN, 5'd3);
    write_reg(msp_pkg::REG_SHELL, 5'd31);
    write_reg(msp_pkg::REG_ATOM, 5'd0);
    send_item(msp_pkg::FN_FIN, 1'b0, 4'd0, 4'd0, '0, '0, '0);
  endtask

  task automatic test_random();
    int n_elem;
    for (int ph = 0; ph < 7; ph++) begin
      quiet = (ph == 6);
      write_reg(msp_pkg::REG_SPIN,
                (ph == 0) ? 5'd1 : (ph == 1) ? 5'd2 : 5'($urandom_range(0, 3)));
      write_reg(msp_pkg::REG_SHELL,
                (ph == 1) ? 5'd16 : (ph == 2) ? 5'd1 : 5'($urandom_range(1, 6)));
      write_reg(msp_pkg::REG_ATOM,
                (ph == 1) ? 5'd16 : (ph == 2) ? 5'd1 : 5'($urandom_range(1, 6)));
      for (int s = 0; s < 6; s++)
        send_item(msp_pkg::FN_SET, 1'($urandom), s[3:0], 4'($urandom_range(0, 7)), pick32(),
                  pick32(), pick48());
      n_elem = $urandom_range(8, 12);
      for (int e = 0; e < n_elem; e++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(2'($urandom_range(0, 3)), 1'($urandom), 4'($urandom), 4'($urandom),
                    $urandom, $urandom, 48'({$urandom_range(0, 65535), $urandom}));
        else
          send_item(msp_pkg::FN_ACC, 1'($urandom), 4'($urandom_range(0, 15) % 6 +
                    ($urandom_range(0, 7) == 0 ? 10 : 0)), 4'($urandom), pick32(), pick32(),
                    '0);
      end
      send_item(msp_pkg::FN_FIN, 1'($urandom), 4'($urandom), 4'($urandom), '0, '0, '0);
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) shell_acc[i] = 0;
    for (int i = 0; i < 16; i++) begin ref_occ[i] = 0; atom_of[i] = '0; end
    sat_err = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("tb_top: %0d items sent, %0d results checked over all spin and count settings",
             items_sent, results_seen);
    if (failures == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
